>>> rtl/cdc_pkg.sv
package cdc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int V1_W     = 34;   // magnitude CORDIC datapath
    localparam int V2_W     = 48;   // lightness CORDIC datapath
    localparam int ROT_W    = 34;   // sine CORDIC datapath

    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic signed [63:0] INV_GAIN_Q30 = 64'sd652032874;
    localparam logic signed [63:0] HUE_CORR_Q32 = 64'sd136713055;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] real_part;
        logic signed [SAMPLE_W-1:0] imag_part;
    } t_cdc_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_cdc_out;

    // atan(2^-i) as a fraction of a turn
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10680862;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41721;
            5'd15: v = 32'd20860;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2607;
            5'd19: v = 32'd1303;
            5'd20: v = 32'd651;
            5'd21: v = 32'd325;
            5'd22: v = 32'd162;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/cdc_vec_cell.sv
module cdc_vec_cell import cdc_pkg::*; #(
    parameter int W     = 34,
    parameter int STAGE = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic signed [W-1:0] i_x,
    input  logic signed [W-1:0] i_y,
    input  logic [31:0]         i_z,
    output logic                o_vld,
    output logic signed [W-1:0] o_x,
    output logic signed [W-1:0] o_y,
    output logic [31:0]         o_z
);

    logic                r_vld;
    logic signed [W-1:0] r_x, r_y, n_x, n_y;
    logic [31:0]         r_z, n_z;

    always_comb begin
        if (i_y > 0) begin
            n_x = i_x + (i_y >>> STAGE);
            n_y = i_y - (i_x >>> STAGE);
            n_z = i_z + atan_turn(5'(STAGE));
        end else begin
            n_x = i_x - (i_y >>> STAGE);
            n_y = i_y + (i_x >>> STAGE);
            n_z = i_z - atan_turn(5'(STAGE));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_vld = r_vld;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

>>> rtl/cdc_rot_cell.sv
module cdc_rot_cell import cdc_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [ROT_W-1:0] i_x,
    input  logic signed [ROT_W-1:0] i_y,
    input  logic signed [ROT_W-1:0] i_z,
    input  logic                    i_neg,
    input  logic [31:0]             i_phase,
    output logic signed [ROT_W-1:0] o_x,
    output logic signed [ROT_W-1:0] o_y,
    output logic signed [ROT_W-1:0] o_z,
    output logic                    o_neg,
    output logic [31:0]             o_phase
);

    logic signed [ROT_W-1:0] r_x, r_y, r_z, n_x, n_y, n_z, w_atan;
    logic                    r_neg;
    logic [31:0]             r_phase;

    assign w_atan = signed'(ROT_W'(atan_turn(5'(STAGE))));

    always_comb begin
        if (i_z >= 0) begin
            n_x = i_x - (i_y >>> STAGE);
            n_y = i_y + (i_x >>> STAGE);
            n_z = i_z - w_atan;
        end else begin
            n_x = i_x + (i_y >>> STAGE);
            n_y = i_y - (i_x >>> STAGE);
            n_z = i_z + w_atan;
        end
    end

    // carry the phase and sign fold alongside the rotation
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_z     <= n_z;
            r_neg   <= i_neg;
            r_phase <= i_phase;
        end
    end

    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_neg   = r_neg;
    assign o_phase = r_phase;

endmodule

>>> rtl/cdc_hsb.sv
module cdc_hsb import cdc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic signed [63:0] i_prod,
    input  logic [31:0]        i_phase,
    input  logic [16:0]        i_sat,
    input  logic [16:0]        i_br,
    output logic               o_vld,
    output t_cdc_out           o_data
);

    logic signed [63:0] w_adj;
    logic [31:0]        w_hue;
    logic [34:0]        w_h6;
    logic [16:0]        w_fc;
    logic [33:0]        w_p, w_sf, w_st;

    logic        r2_vld, r3_vld, r4_vld;
    logic [16:0] r2_br, r2_p, r2_sf, r2_st, r3_br, r3_p, r3_q, r3_t;
    logic [2:0]  r2_sx, r3_sx;
    t_cdc_out    r4_data;

    logic [33:0] w_q, w_t;
    logic [16:0] w_r, w_g, w_b;

    assign w_adj = (i_prod + 64'sd536870912) >>> 30;
    assign w_hue = i_phase + w_adj[31:0];
    assign w_h6  = 35'(w_hue) * 35'd6;
    assign w_fc  = ONE_Q16 - {1'b0, w_h6[31:16]};
    assign w_p   = 34'(i_br) * 34'(ONE_Q16 - i_sat);
    assign w_sf  = 34'(i_sat) * 34'(w_h6[31:16]);
    assign w_st  = 34'(i_sat) * 34'(w_fc);

    assign w_q = 34'(r2_br) * 34'(ONE_Q16 - r2_sf);
    assign w_t = 34'(r2_br) * 34'(ONE_Q16 - r2_st);

    always_comb begin
        case (r3_sx)
            3'd0:    begin w_r = r3_br; w_g = r3_t;  w_b = r3_p;  end
            3'd1:    begin w_r = r3_q;  w_g = r3_br; w_b = r3_p;  end
            3'd2:    begin w_r = r3_p;  w_g = r3_br; w_b = r3_t;  end
            3'd3:    begin w_r = r3_p;  w_g = r3_q;  w_b = r3_br; end
            3'd4:    begin w_r = r3_t;  w_g = r3_p;  w_b = r3_br; end
            default: begin w_r = r3_br; w_g = r3_p;  w_b = r3_q;  end
        endcase
    end

    function automatic logic [7:0] to8(input logic [16:0] v);
        logic [25:0] s;
        s = 26'(v) * 26'd255 + 26'd32768;
        return s[23:16];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= i_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
        if (i_en) begin
            r2_br <= i_br;
            r2_p  <= w_p[32:16];
            r2_sf <= w_sf[32:16];
            r2_st <= w_st[32:16];
            r2_sx <= w_h6[34:32];
            r3_br <= r2_br;
            r3_p  <= r2_p;
            r3_q  <= w_q[32:16];
            r3_t  <= w_t[32:16];
            r3_sx <= r2_sx;
            r4_data.red   <= to8(w_r);
            r4_data.green <= to8(w_g);
            r4_data.blue  <= to8(w_b);
        end
    end

    assign o_vld  = r4_vld;
    assign o_data = r4_data;

endmodule

>>> rtl/complex_domain_coloring.sv
// Domain colouring of complex samples: one request (real, imaginary, Q4.12)
// in, one 8-bit RGB pixel out. A new request is taken every clock while the
// output side keeps up. Each request passes through two chains of CORDIC
// cells (magnitude/phase, then lightness running beside the hue sine) and
// the colour back end. The whole pipeline stalls together when the output
// is held. inverse_radius (Q8.8) is 1/R; write it only when idle.
module complex_domain_coloring import cdc_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_cdc_in     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_cdc_out    o_out_data,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    localparam int N = CORDIC_STAGES;

    logic        w_adv;
    logic [15:0] r_invr;

    logic                   v1_vld [N+1];
    logic signed [V1_W-1:0] v1_x [N+1];
    logic signed [V1_W-1:0] v1_y [N+1];
    logic [31:0]            v1_z [N+1];

    logic                   v2_vld [N+1];
    logic signed [V2_W-1:0] v2_x [N+1];
    logic signed [V2_W-1:0] v2_y [N+1];
    logic [31:0]            v2_z [N+1];

    logic signed [ROT_W-1:0] rt_x [N+1];
    logic signed [ROT_W-1:0] rt_y [N+1];
    logic signed [ROT_W-1:0] rt_z [N+1];
    logic                    rt_neg [N+1];
    logic [31:0]             rt_ph [N+1];

    logic signed [V1_W-1:0] w_x0, w_y0;
    logic [31:0]            w_z0;

    logic               r_m1_vld, r_m2_vld, r_h1_vld;
    logic signed [63:0] r_m1_prod, r_h1_prod;
    logic [31:0]        r_m1_ph, r_h1_ph;

    logic signed [63:0]     w_mag;
    logic [31:0]            w_a3, w_a;
    logic                   w_neg;
    logic signed [V2_W-1:0] r_m2_y;
    logic signed [ROT_W-1:0] r_m2_rz;
    logic                   r_m2_neg;
    logic [31:0]            r_m2_ph;

    logic signed [32:0]  w_lt;
    logic signed [18:0]  w_li;
    logic [16:0]         w_lc, w_sat, w_br, r_h1_sat, r_h1_br;
    logic signed [ROT_W-1:0] w_sn;

    // advance the whole pipeline unless a finished pixel is being held
    assign w_adv      = !o_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invr <= 16'd256;
        end else if (i_cfg_we) begin
            r_invr <= i_cfg_wdata;
        end
    end

    // fold the left half-plane onto the right before vectoring
    always_comb begin
        w_x0 = V1_W'(i_in_data.real_part) <<< 12;
        w_y0 = V1_W'(i_in_data.imag_part) <<< 12;
        w_z0 = 32'd0;
        if (w_x0 < 0) begin
            w_x0 = -w_x0;
            w_y0 = -w_y0;
            w_z0 = HALF_TURN;
        end
    end
    assign v1_vld[0] = i_in_valid;
    assign v1_x[0]   = w_x0;
    assign v1_y[0]   = w_y0;
    assign v1_z[0]   = w_z0;

    for (genvar g = 0; g < N; g++) begin : g_mag
        cdc_vec_cell #(.W(V1_W), .STAGE(g)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv),
            .i_vld(v1_vld[g]), .i_x(v1_x[g]), .i_y(v1_y[g]), .i_z(v1_z[g]),
            .o_vld(v1_vld[g+1]), .o_x(v1_x[g+1]), .o_y(v1_y[g+1]), .o_z(v1_z[g+1])
        );
    end

    // remove the CORDIC gain, then scale by 1/R and fold 3*phase
    assign w_mag = (r_m1_prod + 64'sd536870912) >>> 30;
    assign w_a3  = r_m1_ph + {r_m1_ph[30:0], 1'b0};
    always_comb begin
        w_a   = w_a3;
        w_neg = 1'b0;
        if (((w_a3 + QUARTER_TURN) & HALF_TURN) != 32'd0) begin
            w_a   = w_a3 - HALF_TURN;
            w_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
            r_m2_vld <= 1'b0;
            r_h1_vld <= 1'b0;
        end else if (w_adv) begin
            r_m1_vld <= v1_vld[N];
            r_m2_vld <= r_m1_vld;
            r_h1_vld <= v2_vld[N];
        end
        if (w_adv) begin
            r_m1_prod <= 64'(v1_x[N]) * INV_GAIN_Q30;
            r_m1_ph   <= v1_z[N] + HALF_TURN;
            r_m2_y    <= V2_W'(w_mag) * V2_W'(signed'({1'b0, r_invr}));
            r_m2_rz   <= ROT_W'(signed'(w_a));
            r_m2_neg  <= w_neg;
            r_m2_ph   <= r_m1_ph;
            r_h1_prod <= 64'(w_sn) * HUE_CORR_Q32;
            r_h1_ph   <= rt_ph[N];
            r_h1_sat  <= w_sat;
            r_h1_br   <= w_br;
        end
    end

    assign v2_vld[0] = r_m2_vld;
    assign v2_x[0]   = V2_W'(64'sd4294967296);
    assign v2_y[0]   = r_m2_y;
    assign v2_z[0]   = 32'd0;

    assign rt_x[0]   = ROT_W'(INV_GAIN_Q30);
    assign rt_y[0]   = '0;
    assign rt_z[0]   = r_m2_rz;
    assign rt_neg[0] = r_m2_neg;
    assign rt_ph[0]  = r_m2_ph;

    for (genvar g = 0; g < N; g++) begin : g_lum
        cdc_vec_cell #(.W(V2_W), .STAGE(g)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv),
            .i_vld(v2_vld[g]), .i_x(v2_x[g]), .i_y(v2_y[g]), .i_z(v2_z[g]),
            .o_vld(v2_vld[g+1]), .o_x(v2_x[g+1]), .o_y(v2_y[g+1]), .o_z(v2_z[g+1])
        );
        cdc_rot_cell #(.STAGE(g)) u_sin (
            .i_clk(i_clk), .i_en(w_adv),
            .i_x(rt_x[g]), .i_y(rt_y[g]), .i_z(rt_z[g]),
            .i_neg(rt_neg[g]), .i_phase(rt_ph[g]),
            .o_x(rt_x[g+1]), .o_y(rt_y[g+1]), .o_z(rt_z[g+1]),
            .o_neg(rt_neg[g+1]), .o_phase(rt_ph[g+1])
        );
    end

    // lightness in Q16, clamped to 0..1
    assign w_lt = 33'(signed'(v2_z[N])) + 33'sd8192;
    assign w_li = 19'(w_lt >>> 14);
    always_comb begin
        if (w_li < 0) begin
            w_lc = '0;
        end else if (w_li > 19'sd65536) begin
            w_lc = ONE_Q16;
        end else begin
            w_lc = w_li[16:0];
        end
        if (w_lc < 17'd32768) begin
            w_sat = ONE_Q16;
            w_br  = {w_lc[15:0], 1'b0};
        end else begin
            w_sat = 17'(18'd131072 - {w_lc, 1'b0});
            w_br  = ONE_Q16;
        end
    end
    assign w_sn = rt_neg[N] ? -rt_y[N] : rt_y[N];

    cdc_hsb u_hsb (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv),
        .i_vld(r_h1_vld), .i_prod(r_h1_prod), .i_phase(r_h1_ph),
        .i_sat(r_h1_sat), .i_br(r_h1_br),
        .o_vld(o_out_valid), .o_data(o_out_data)
    );

endmodule
